@@ rtl/core/bitmap_frame_allocator_core_macros.svh @@
// assertion helpers for the checker file
`ifndef BITMAP_FRAME_ALLOCATOR_CORE_MACROS_SVH
`define BITMAP_FRAME_ALLOCATOR_CORE_MACROS_SVH

// concurrent assertion, ignored while reset is held
`define BFA_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent assertion, also checked during reset
`define BFA_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/bfa_pkg.sv @@
package bfa_pkg;

  // field widths
  localparam int FRAME_W  = 20;
  localparam int COUNT_W  = 13;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // stream payload widths, padded to whole bytes
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 40;
  localparam int IN_PAD     = IN_DATA_W - FRAME_W - COUNT_W;
  localparam int OUT_PAD    = OUT_DATA_W - FRAME_W - COUNT_W;

  // default sizing
  localparam int MAX_FRAMES_DEF = 4096;
  localparam int WORD_BITS_DEF  = 64;

  // register reset values
  localparam logic [FRAME_W-1:0] BASE_RST = '0;
  localparam int                 POOL_RST = 4096;
  localparam logic               RESV_RST = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BASE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RESV = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_INIT  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_FREE  = 2'd2,
    CMD_MARK  = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 2'd0,
    ST_EMPTY        = 2'd1,
    ST_OUTSIDE      = 2'd2,
    ST_ALREADY_FREE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_SEG,
    S_LOAD,
    S_RD,
    S_MOD,
    S_RESP
  } state_t;

endpackage

@@ rtl/core/bfa_ram.sv @@
module bfa_ram
  import bfa_pkg::*;
#(
  parameter int DEPTH = 64,
  parameter int WIDTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // single port, read returns the old word on a same-cycle write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/bfa_idx_split.sv @@
module bfa_idx_split
  import bfa_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF,
  localparam int NWORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS,
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1,
  localparam int BW     = $clog2(WORD_BITS),
  localparam int IDX_W  = $clog2(MAX_FRAMES)
) (
  input  logic             clk,
  input  logic [IDX_W-1:0] idx_in,
  output logic [AW-1:0]    word_out,
  output logic [BW-1:0]    bit_out
);

  // reciprocal scaled so the quotient is exact over the whole index range
  localparam int SH    = IDX_W + BW;
  localparam int RECIP = ((1 << SH) + WORD_BITS - 1) / WORD_BITS;
  localparam int RW    = $clog2(RECIP + 1);
  localparam int PW    = IDX_W + RW;

  logic [PW-1:0]    prod_r;
  logic [IDX_W-1:0] idx_d_r;
  logic [PW-1:0]    quot;
  logic [IDX_W-1:0] wbase;
  logic [IDX_W-1:0] rem;

  // stage one: multiply by the reciprocal
  always_ff @(posedge clk) begin
    prod_r  <= PW'(idx_in) * PW'(RECIP);
    idx_d_r <= idx_in;
  end

  // stage two: quotient and remainder
  always_comb begin
    quot  = prod_r >> SH;
    wbase = IDX_W'(quot) * IDX_W'(WORD_BITS);
    rem   = idx_d_r - wbase;
  end

  assign word_out = AW'(quot);
  assign bit_out  = BW'(rem);

endmodule

@@ rtl/core/bitmap_frame_allocator_core.sv @@
// First-fit physical frame allocator. A free bitmap (bit set = free) of
// MAX_FRAMES bits sits in a single-port RAM of WORD_BITS-wide words, and a
// counter tracks the free frames. Each command returns exactly one result:
// init rebuilds the bitmap from the current pool size, allocate hands out the
// lowest free frame as base_frame plus index, release frees an in-use frame,
// and mark takes a range of frames (range parts outside the pool give status
// 2). Commands run one at a time. Every bitmap word touched takes a RAM read,
// then a modify and write back. Init and the pass after reset write one word
// per cycle over all ceil(MAX_FRAMES/WORD_BITS) words (64 by default),
// during which no command is accepted; configuration writes are always taken.
// Allocate scans words upward from the first until a free frame turns up or
// the pool ends, release goes through the index split and one word, and mark
// through the index split and every word covered, with a pool check per
// stretch outside the pool. A result sits in an output register, so the next
// command can be accepted while it waits to be taken.
module bitmap_frame_allocator_core
  import bfa_pkg::*;
#(
  parameter int MAX_FRAMES = MAX_FRAMES_DEF,
  parameter int WORD_BITS  = WORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // input stream
  input  logic                  in_tvalid,
  output logic                  in_tready,
  input  logic [IN_DATA_W-1:0]  in_tdata,   // frame[19:0], count[32:20], zero pad
  input  logic [CMD_W-1:0]      in_tuser,   // cmd[1:0]
  // result stream
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [OUT_DATA_W-1:0] out_tdata,  // frame_out[19:0], free_count[32:20], zero pad
  output logic [STATUS_W-1:0]   out_tuser,  // status[1:0]
  // configuration writes
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NWORDS = (MAX_FRAMES + WORD_BITS - 1) / WORD_BITS;
  localparam int AW     = (NWORDS > 1) ? $clog2(NWORDS) : 1;
  localparam int BW     = $clog2(WORD_BITS);
  localparam int IDX_W  = $clog2(MAX_FRAMES);
  localparam int SPAN   = NWORDS * WORD_BITS;
  localparam int IW     = $clog2(SPAN + 1);
  localparam int NW     = $clog2(MAX_FRAMES + 1);
  localparam int LIM_W  = $clog2(WORD_BITS + 1);
  localparam int RNG_W  = $clog2(WORD_BITS + (1 << COUNT_W));
  localparam int PF_W   = (IW > COUNT_W) ? IW : COUNT_W;
  localparam int INIT_N_RST = (POOL_RST > MAX_FRAMES) ? MAX_FRAMES : POOL_RST;

  // configuration registers
  logic [FRAME_W-1:0] base_r;
  logic [COUNT_W-1:0] pool_r;
  logic               resv_r;

  // command state
  state_t              state_r, state_nxt;
  cmd_t                cmd_r, cmd_nxt;
  logic [FRAME_W-1:0]  cur_r, cur_nxt;
  logic [COUNT_W-1:0]  rem_r, rem_nxt;
  status_t             status_r, status_nxt;
  logic [FRAME_W-1:0]  frame_out_r, frame_out_nxt;
  logic [AW-1:0]       w_r, w_nxt;
  logic [BW-1:0]       b_r, b_nxt;
  logic [IW-1:0]       wbase_r, wbase_nxt;
  logic [LIM_W-1:0]    pop_r, pop_nxt;
  logic [NW-1:0]       free_r, free_nxt;
  logic [NW-1:0]       init_n_r, init_n_nxt;
  logic                init_res_r, init_res_nxt;
  logic                sweep_resp_r, sweep_resp_nxt;

  // result register
  logic                out_valid_r;
  logic [FRAME_W-1:0]  out_frame_r;
  status_t             out_status_r;
  logic [COUNT_W-1:0]  out_free_r;
  logic                out_load;

  // bitmap memory
  logic                 mem_we;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [WORD_BITS-1:0] rdata;

  // index split
  logic [AW-1:0] spl_word;
  logic [BW-1:0] spl_bit;

  // word datapath
  logic [NW-1:0]        psz;
  logic [NW-1:0]        n_sel;
  logic [IW-1:0]        lim_diff;
  logic [LIM_W-1:0]     pool_lim;
  logic [WORD_BITS-1:0] pool_mask;
  logic [RNG_W-1:0]     bend;
  logic [WORD_BITS-1:0] rng_mask;
  logic [WORD_BITS-1:0] res_bit;
  logic [WORD_BITS-1:0] init_word;
  logic [WORD_BITS-1:0] avail_bits;
  logic [WORD_BITS-1:0] low_bit;
  logic [BW-1:0]        low_idx;
  logic                 found;
  logic [FRAME_W-1:0]   alloc_frame;
  logic [WORD_BITS-1:0] take_bits;
  logic [LIM_W-1:0]     take_pop;
  logic [LIM_W-1:0]     avail_cnt;
  logic [IW:0]          nb;
  logic [WORD_BITS-1:0] rel_bit;
  logic                 cur_out;
  logic [FRAME_W:0]     room;

  // input fields
  logic               in_fire;
  cmd_t               in_cmd;
  logic [FRAME_W-1:0] in_frame;
  logic [COUNT_W-1:0] in_count;

  assign in_fire  = in_tvalid && in_tready;
  assign in_cmd   = cmd_t'(in_tuser);
  assign in_frame = in_tdata[FRAME_W-1:0];
  assign in_count = in_tdata[FRAME_W+COUNT_W-1:FRAME_W];
  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  bfa_ram #(
    .DEPTH (NWORDS),
    .WIDTH (WORD_BITS)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (w_r),
    .wdata (mem_wdata),
    .rdata (rdata)
  );

  bfa_idx_split #(
    .MAX_FRAMES (MAX_FRAMES),
    .WORD_BITS  (WORD_BITS)
  ) u_split (
    .clk      (clk),
    .idx_in   (cur_r[IDX_W-1:0]),
    .word_out (spl_word),
    .bit_out  (spl_bit)
  );

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RST;
      pool_r <= COUNT_W'(POOL_RST);
      resv_r <= RESV_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_BASE: base_r <= cfg_data[FRAME_W-1:0];
        CFG_POOL: pool_r <= cfg_data[COUNT_W-1:0];
        CFG_RESV: resv_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective pool size and its reach into the current word
  always_comb begin
    psz = (PF_W'(pool_r) > PF_W'(MAX_FRAMES)) ? NW'(MAX_FRAMES) : NW'(pool_r);
    n_sel = (state_r == S_INIT) ? init_n_r : psz;
    lim_diff = (IW'(n_sel) > wbase_r) ? (IW'(n_sel) - wbase_r) : '0;
    pool_lim = (lim_diff > IW'(WORD_BITS)) ? LIM_W'(WORD_BITS) : LIM_W'(lim_diff);
    nb = (IW + 1)'(wbase_r) + (IW + 1)'(WORD_BITS);
    cur_out = (cur_r >= FRAME_W'(psz));
    room = (FRAME_W + 1)'(1 << FRAME_W) - (FRAME_W + 1)'(cur_r);
  end

  // bit masks over the current word
  always_comb begin
    bend = RNG_W'(b_r) + RNG_W'(rem_r);
    for (int j = 0; j < WORD_BITS; j++) begin
      pool_mask[j] = (LIM_W'(j) < pool_lim);
      rng_mask[j]  = (RNG_W'(j) >= RNG_W'(b_r)) && (RNG_W'(j) < bend);
    end
    res_bit = {{(WORD_BITS-1){1'b0}}, init_res_r && (wbase_r == '0)};
    init_word = pool_mask & ~res_bit;
    rel_bit = WORD_BITS'(1) << b_r;
  end

  // lowest free bit inside the pool
  always_comb begin
    avail_bits = rdata & pool_mask;
    low_bit = avail_bits & (~avail_bits + WORD_BITS'(1));
    found = |avail_bits;
    low_idx = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      if (low_bit[j]) begin
        low_idx = low_idx | BW'(j);
      end
    end
    alloc_frame = base_r + FRAME_W'(wbase_r) + FRAME_W'(low_idx);
  end

  // frames of a marked range that are newly taken
  always_comb begin
    take_bits = rdata & pool_mask & rng_mask;
    take_pop = '0;
    for (int j = 0; j < WORD_BITS; j++) begin
      take_pop = take_pop + LIM_W'(take_bits[j]);
    end
    avail_cnt = pool_lim - LIM_W'(b_r);
  end

  // command sequencer
  always_comb begin
    state_nxt      = state_r;
    cmd_nxt        = cmd_r;
    cur_nxt        = cur_r;
    rem_nxt        = rem_r;
    status_nxt     = status_r;
    frame_out_nxt  = frame_out_r;
    w_nxt          = w_r;
    b_nxt          = b_r;
    wbase_nxt      = wbase_r;
    init_n_nxt     = init_n_r;
    init_res_nxt   = init_res_r;
    sweep_resp_nxt = sweep_resp_r;
    pop_nxt        = '0;
    free_nxt       = free_r - ((NW'(pop_r) > free_r) ? free_r : NW'(pop_r));
    mem_we         = 1'b0;
    mem_wdata      = init_word;
    out_load       = 1'b0;

    unique case (state_r)
      S_INIT: begin
        mem_we = 1'b1;
        mem_wdata = init_word;
        if (w_r == AW'(NWORDS - 1)) begin
          free_nxt = init_n_r - NW'(init_res_r && (init_n_r != '0));
          state_nxt = sweep_resp_r ? S_RESP : S_IDLE;
        end else begin
          w_nxt = w_r + AW'(1);
          wbase_nxt = wbase_r + IW'(WORD_BITS);
        end
      end

      S_IDLE: begin
        if (in_fire) begin
          cmd_nxt = in_cmd;
          cur_nxt = in_frame - base_r;
          rem_nxt = in_count;
          status_nxt = ST_OK;
          frame_out_nxt = '0;
          w_nxt = '0;
          wbase_nxt = '0;
          unique case (in_cmd)
            CMD_INIT: begin
              init_n_nxt = psz;
              init_res_nxt = resv_r;
              sweep_resp_nxt = 1'b1;
              state_nxt = S_INIT;
            end
            CMD_ALLOC: begin
              if (free_r == '0) begin
                status_nxt = ST_EMPTY;
                state_nxt = S_RESP;
              end else begin
                state_nxt = S_RD;
              end
            end
            CMD_FREE, CMD_MARK: begin
              state_nxt = S_SEG;
            end
          endcase
        end
      end

      // pool check, skips stretches outside the pool
      S_SEG: begin
        if (cmd_r == CMD_FREE) begin
          if (cur_out) begin
            status_nxt = ST_OUTSIDE;
            state_nxt = S_RESP;
          end else begin
            state_nxt = S_LOAD;
          end
        end else if (rem_r == '0) begin
          state_nxt = S_RESP;
        end else if (cur_out) begin
          status_nxt = ST_OUTSIDE;
          if ((FRAME_W + 1)'(rem_r) <= room) begin
            rem_nxt = '0;
            state_nxt = S_RESP;
          end else begin
            rem_nxt = rem_r - COUNT_W'(room);
            cur_nxt = '0;
          end
        end else begin
          state_nxt = S_LOAD;
        end
      end

      // word and bit position of the cursor
      S_LOAD: begin
        w_nxt = spl_word;
        b_nxt = spl_bit;
        wbase_nxt = IW'(cur_r) - IW'(spl_bit);
        state_nxt = S_RD;
      end

      S_RD: begin
        state_nxt = S_MOD;
      end

      // read-modify-write of one bitmap word
      S_MOD: begin
        unique case (cmd_r)
          CMD_ALLOC: begin
            if (found) begin
              mem_we = 1'b1;
              mem_wdata = rdata & ~low_bit;
              frame_out_nxt = alloc_frame;
              free_nxt = (free_r != '0) ? (free_r - NW'(1)) : '0;
              state_nxt = S_RESP;
            end else if (nb >= (IW + 1)'(psz)) begin
              status_nxt = ST_EMPTY;
              state_nxt = S_RESP;
            end else begin
              w_nxt = w_r + AW'(1);
              wbase_nxt = IW'(nb);
              state_nxt = S_RD;
            end
          end
          CMD_FREE: begin
            if (rdata[b_r]) begin
              status_nxt = ST_ALREADY_FREE;
            end else begin
              mem_we = 1'b1;
              mem_wdata = rdata | rel_bit;
              free_nxt = free_r + NW'(1);
            end
            state_nxt = S_RESP;
          end
          CMD_MARK: begin
            mem_we = 1'b1;
            mem_wdata = rdata & ~take_bits;
            pop_nxt = take_pop;
            if (rem_r <= COUNT_W'(avail_cnt)) begin
              rem_nxt = '0;
              state_nxt = S_RESP;
            end else begin
              rem_nxt = rem_r - COUNT_W'(avail_cnt);
              if (nb >= (IW + 1)'(psz)) begin
                cur_nxt = FRAME_W'(psz);
                state_nxt = S_SEG;
              end else begin
                w_nxt = w_r + AW'(1);
                b_nxt = '0;
                wbase_nxt = IW'(nb);
                state_nxt = S_RD;
              end
            end
          end
          CMD_INIT: begin
            state_nxt = S_IDLE;
          end
        endcase
      end

      S_RESP: begin
        if (!out_valid_r || out_tready) begin
          out_load = 1'b1;
          state_nxt = S_IDLE;
        end
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_INIT;
      w_r          <= '0;
      wbase_r      <= '0;
      pop_r        <= '0;
      free_r       <= '0;
      init_n_r     <= NW'(INIT_N_RST);
      init_res_r   <= RESV_RST;
      sweep_resp_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      w_r          <= w_nxt;
      wbase_r      <= wbase_nxt;
      pop_r        <= pop_nxt;
      free_r       <= free_nxt;
      init_n_r     <= init_n_nxt;
      init_res_r   <= init_res_nxt;
      sweep_resp_r <= sweep_resp_nxt;
    end
  end

  // command payload registers
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    cur_r       <= cur_nxt;
    rem_r       <= rem_nxt;
    status_r    <= status_nxt;
    frame_out_r <= frame_out_nxt;
    b_r         <= b_nxt;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_frame_r  <= frame_out_r;
      out_status_r <= status_r;
      out_free_r   <= COUNT_W'(free_nxt);
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD{1'b0}}, out_free_r, out_frame_r};
  assign out_tuser  = out_status_r;

endmodule

@@ rtl/core/bfa_chk.sv @@
`include "bitmap_frame_allocator_core_macros.svh"

module bfa_chk
  import bfa_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic [STATUS_W-1:0]   out_tuser
);

  // a stalled result holds its payload
  `BFA_ASSERT(a_out_hold, clk, rst_n, out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // a failed command never reports a frame
  `BFA_ASSERT(a_err_no_frame, clk, rst_n, out_tvalid && (out_tuser != ST_OK) |-> (out_tdata[FRAME_W-1:0] == '0), "frame reported with error status")

  // one command at a time
  `BFA_ASSERT(a_one_cmd, clk, rst_n, in_tvalid && in_tready |=> !in_tready, "command accepted while busy")

  // the bitmap clearing pass follows every reset
  `BFA_ASSERT_ALWAYS(a_rst_busy, clk, !rst_n |=> !in_tready, "command accepted during clearing pass")

endmodule

bind bitmap_frame_allocator_core bfa_chk u_bfa_chk (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import bfa_pkg::*;

  localparam int POOL_MAX = MAX_FRAMES_DEF;
  localparam int NDIR     = 22;
  localparam int NPHASE   = 9;

  typedef struct {
    logic [FRAME_W-1:0] frame_out;
    status_t            status;
    logic [COUNT_W-1:0] free_count;
  } alloc_result_t;

  typedef struct {
    cmd_t               op;
    logic [FRAME_W-1:0] frame;
    logic [COUNT_W-1:0] count;
    bit                 typed;
    logic [FRAME_W-1:0] e_frame;
    status_t            e_status;
    logic [COUNT_W-1:0] e_free;
  } dir_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;
  logic [CMD_W-1:0]      in_tuser = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic [STATUS_W-1:0]   out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow copy of the allocator state
  bit   [POOL_MAX-1:0]   shadow_map;
  int unsigned           shadow_free;
  logic [FRAME_W-1:0]    shadow_base;
  logic [COUNT_W-1:0]    shadow_pool;
  bit                    shadow_resv;

  alloc_result_t         pending_results[$];
  logic [FRAME_W-1:0]    held_frames[$];
  int                    fail_count = 0;
  bit                    idle_on = 1'b1;
  bit                    hold_go = 1'b0;
  logic                  rx_hold = 1'b0;
  int                    rx_stall = 0;

  bitmap_frame_allocator_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog
  initial begin
    #3_000_000;
    $display("tb: failure");
    $finish;
  end

  function automatic int pool_eff();
    return (shadow_pool > POOL_MAX) ? POOL_MAX : int'(shadow_pool);
  endfunction

  // rebuild the free map from the current pool size
  function automatic void shadow_rebuild();
    int n;
    n = pool_eff();
    shadow_map = '0;
    for (int i = 0; i < n; i++) shadow_map[i] = 1'b1;
    shadow_free = n;
    if (shadow_resv && n > 0) begin
      shadow_map[0] = 1'b0;
      shadow_free--;
    end
  endfunction

  function automatic void shadow_take(int idx);
    if (shadow_map[idx]) begin
      shadow_map[idx] = 1'b0;
      if (shadow_free > 0) shadow_free--;
    end
  endfunction

  // expected result of one command, updating the shadow state
  function automatic alloc_result_t alloc_predict(cmd_t op, logic [FRAME_W-1:0] f,
                                                  logic [COUNT_W-1:0] c);
    alloc_result_t res;
    int n;
    int hit;
    logic [FRAME_W-1:0] idx;
    logic [FRAME_W-1:0] off;
    n = pool_eff();
    hit = -1;
    res.frame_out = '0;
    res.status = ST_OK;
    case (op)
      CMD_INIT: begin
        shadow_rebuild();
        held_frames.delete();
      end
      CMD_ALLOC: begin
        if (shadow_free > 0) begin
          for (int i = 0; i < n && hit < 0; i++) if (shadow_map[i]) hit = i;
        end
        if (hit >= 0) begin
          shadow_take(hit);
          res.frame_out = shadow_base + FRAME_W'(hit);
          held_frames.push_back(res.frame_out);
        end else begin
          res.status = ST_EMPTY;
        end
      end
      CMD_FREE: begin
        idx = f - shadow_base;
        if (idx >= n) res.status = ST_OUTSIDE;
        else if (shadow_map[idx]) res.status = ST_ALREADY_FREE;
        else begin
          shadow_map[idx] = 1'b1;
          shadow_free++;
        end
      end
      default: begin
        for (int i = 0; i < int'(c); i++) begin
          off = FRAME_W'(i);
          idx = f + off - shadow_base;
          if (idx < n) shadow_take(int'(idx));
          else res.status = ST_OUTSIDE;
        end
      end
    endcase
    res.free_count = shadow_free[COUNT_W-1:0];
    return res;
  endfunction

  // compare one result transaction with the oldest expectation
  task automatic check_result();
    alloc_result_t want;
    if (pending_results.size() == 0) begin
      $error("result with no expectation: frame_out %0h status %0d free_count %0d",
             out_tdata[FRAME_W-1:0], out_tuser, out_tdata[FRAME_W+COUNT_W-1:FRAME_W]);
      fail_count++;
    end else begin
      want = pending_results.pop_front();
      if (out_tdata[FRAME_W-1:0] !== want.frame_out) begin
        $error("frame_out: expected %0h actual %0h", want.frame_out, out_tdata[FRAME_W-1:0]);
        fail_count++;
      end
      if (out_tuser !== want.status) begin
        $error("status: expected %0d actual %0d", want.status, out_tuser);
        fail_count++;
      end
      if (out_tdata[FRAME_W+COUNT_W-1:FRAME_W] !== want.free_count) begin
        $error("free_count: expected %0d actual %0d", want.free_count,
               out_tdata[FRAME_W+COUNT_W-1:FRAME_W]);
        fail_count++;
      end
    end
  endtask

  // receiver readiness for the next cycle
  function automatic logic rx_next_ready();
    int r;
    if (rx_hold) return 1'b0;
    if (!idle_on) return 1'b1;
    if (rx_stall > 0) begin
      rx_stall--;
      return 1'b0;
    end
    r = $urandom_range(0, 99);
    if (r < 20) begin
      rx_stall = $urandom_range(0, 2);
      return 1'b0;
    end
    if (r < 23) begin
      rx_stall = $urandom_range(15, 50);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // result side
  initial begin
    forever begin
      @(posedge clk);
      if (rst_n && out_tvalid && out_tready) check_result();
      out_tready <= rx_next_ready();
    end
  end

  // long receiver hold-off while commands keep coming
  initial begin
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (400) @(posedge clk);
    rx_hold <= 1'b0;
  end

  function automatic int tx_gap();
    int r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // one command transaction; typed expectation used where given
  task automatic send_cmd(input cmd_t op, input logic [FRAME_W-1:0] f,
                          input logic [COUNT_W-1:0] c, input bit typed,
                          input alloc_result_t typed_res);
    alloc_result_t res;
    int gap;
    in_tuser  <= op;
    in_tdata  <= {IN_PAD'(0), c, f};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    res = alloc_predict(op, f, c);
    pending_results.push_back(typed ? typed_res : res);
    gap = tx_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending until every result has come, then settle
  task automatic drain(input int settle);
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
    repeat (settle) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] d);
    cfg_index <= idx;
    cfg_data  <= d;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_BASE: shadow_base = d;
      CFG_POOL: shadow_pool = d[COUNT_W-1:0];
      CFG_RESV: shadow_resv = d[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // random command, mostly well-formed for the current pool
  task automatic random_cmd();
    alloc_result_t none;
    logic [FRAME_W-1:0] f;
    logic [COUNT_W-1:0] c;
    cmd_t op;
    int n;
    int r;
    int k;
    int j;
    none = '{frame_out: '0, status: ST_OK, free_count: '0};
    n = pool_eff();
    f = FRAME_W'($urandom);
    c = COUNT_W'($urandom);
    r = $urandom_range(0, 99);
    if (r < 4) begin
      op = CMD_INIT;
    end else if (r < 38) begin
      op = CMD_ALLOC;
    end else if (r < 70) begin
      op = CMD_FREE;
      k = $urandom_range(0, 99);
      if (k < 65 && held_frames.size() > 0) begin
        j = $urandom_range(0, held_frames.size() - 1);
        f = held_frames[j];
        held_frames.delete(j);
      end else if (k < 90) begin
        f = shadow_base + FRAME_W'($urandom_range(0, n));
      end
    end else begin
      op = CMD_MARK;
      if ($urandom_range(0, 99) < 80) f = shadow_base + FRAME_W'($urandom_range(0, n));
      k = $urandom_range(0, 99);
      if (k < 70) c = COUNT_W'($urandom_range(0, 16));
      else if (k < 90) c = COUNT_W'($urandom_range(17, 300));
      else if (k < 94) c = COUNT_W'(POOL_MAX);
      else if (k < 98) c = COUNT_W'($urandom_range(301, POOL_MAX));
    end
    send_cmd(op, f, c, 1'b0, none);
  endtask

  // main sequence
  initial begin
    dir_row_t dir_tab [NDIR];
    logic [FRAME_W-1:0] ph_base [NPHASE];
    logic [COUNT_W-1:0] ph_pool [NPHASE];
    bit ph_resv [NPHASE];
    bit ph_init [NPHASE];
    alloc_result_t typed_res;
    alloc_result_t none;

    none = '{frame_out: '0, status: ST_OK, free_count: '0};
    // reset value 4095 free: index 0 kept for management info
    dir_tab = '{
      '{CMD_ALLOC, 20'h00000, 13'd0,    1'b1, 20'd1,    ST_OK,           13'd4094},
      '{CMD_ALLOC, 20'hFFFFF, 13'h1FFF, 1'b1, 20'd2,    ST_OK,           13'd4093},
      '{CMD_FREE,  20'd1,     13'd0,    1'b1, 20'd0,    ST_OK,           13'd4094},
      '{CMD_FREE,  20'd1,     13'd0,    1'b1, 20'd0,    ST_ALREADY_FREE, 13'd4094},
      '{CMD_FREE,  20'd0,     13'd0,    1'b1, 20'd0,    ST_OK,           13'd4095},
      '{CMD_ALLOC, 20'h00000, 13'd0,    1'b1, 20'd0,    ST_OK,           13'd4094},
      '{CMD_FREE,  20'd4096,  13'd0,    1'b1, 20'd0,    ST_OUTSIDE,      13'd4094},
      '{CMD_FREE,  20'hFFFFF, 13'h1FFF, 1'b1, 20'd0,    ST_OUTSIDE,      13'd4094},
      '{CMD_MARK,  20'd0,     13'd0,    1'b1, 20'd0,    ST_OK,           13'd4094},
      '{CMD_MARK,  20'd4090,  13'd10,   1'b0, 20'd0,    ST_OK,           13'd0},
      '{CMD_MARK,  20'hFFFFF, 13'd2,    1'b0, 20'd0,    ST_OK,           13'd0},
      '{CMD_INIT,  20'hFFFFF, 13'h1FFF, 1'b1, 20'd0,    ST_OK,           13'd4095},
      '{CMD_MARK,  20'd0,     13'd4096, 1'b1, 20'd0,    ST_OK,           13'd0},
      '{CMD_ALLOC, 20'h00000, 13'd0,    1'b1, 20'd0,    ST_EMPTY,        13'd0},
      '{CMD_FREE,  20'd4095,  13'd0,    1'b1, 20'd0,    ST_OK,           13'd1},
      '{CMD_ALLOC, 20'h00000, 13'd0,    1'b1, 20'd4095, ST_OK,           13'd0},
      '{CMD_MARK,  20'd0,     13'h1FFF, 1'b0, 20'd0,    ST_OK,           13'd0},
      '{CMD_INIT,  20'h00000, 13'd0,    1'b1, 20'd0,    ST_OK,           13'd4095},
      '{CMD_MARK,  20'h5A5A5, 13'h1555, 1'b0, 20'd0,    ST_OK,           13'd0},
      '{CMD_MARK,  20'h00AAA, 13'h0AAA, 1'b0, 20'd0,    ST_OK,           13'd0},
      '{CMD_ALLOC, 20'hA5A5A, 13'h0AAA, 1'b0, 20'd0,    ST_OK,           13'd0},
      '{CMD_INIT,  20'h00000, 13'd0,    1'b1, 20'd0,    ST_OK,           13'd4095}
    };

    // pool settings per phase: wrap at the top, single frame, empty pool,
    // oversized pool, and a shrink without rebuilding the map
    ph_base = '{20'hFFFFF, 20'h12345, 20'h12345, 20'h00000, 20'hFFFC0,
                20'hFFFC0, 20'h80000, 20'h00000, 20'h00000};
    ph_pool = '{13'd4096, 13'd1, 13'd1, 13'd0, 13'h1FFF, 13'd100, 13'd200, 13'd37, 13'd4096};
    ph_resv = '{1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1};
    ph_init = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1};
    ph_base[7] = FRAME_W'($urandom);
    ph_pool[7] = COUNT_W'($urandom_range(1, 300));
    ph_resv[7] = 1'($urandom_range(0, 1));

    // reset
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    shadow_base = BASE_RST;
    shadow_pool = COUNT_W'(POOL_RST);
    shadow_resv = RESV_RST;
    shadow_rebuild();

    // directed part
    for (int i = 0; i < NDIR; i++) begin
      typed_res = '{dir_tab[i].e_frame, dir_tab[i].e_status, dir_tab[i].e_free};
      send_cmd(dir_tab[i].op, dir_tab[i].frame, dir_tab[i].count, dir_tab[i].typed,
               typed_res);
    end

    // random phases under different pool settings
    for (int p = 0; p < NPHASE; p++) begin
      drain(150);
      idle_on = (p % 3) != 1;
      cfg_write(CFG_BASE, ph_base[p]);
      cfg_write(CFG_POOL, {7'($urandom), ph_pool[p]});
      cfg_write(CFG_RESV, {19'($urandom), ph_resv[p]});
      if (ph_init[p]) send_cmd(CMD_INIT, FRAME_W'($urandom), COUNT_W'($urandom), 1'b0, none);
      if (p == 0) hold_go = 1'b1;
      for (int k = 0; k < 50; k++) begin
        random_cmd();
        if ($urandom_range(0, 99) < 2) drain(0);
      end
    end

    // wait for the last results
    drain(200);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
